@@ rtl/core/qgmb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qgmb_pkg
// Types, constants and shared helpers of the quadric grid mesh builder.
// ----------------------------------------------------------------------------
package qgmb_pkg;

  localparam int DATA_W  = 32;
  localparam int CFG_AW  = 5;
  localparam int GRID_W  = 9;
  localparam int IDX_W   = 8;
  localparam int VIDX_W  = 16;
  localparam int ACC_W   = 52;
  localparam int DIVD_W  = 33;
  localparam int DCNT_W  = 6;

  localparam logic [GRID_W-1:0] MIN_GRID   = 9'd4;
  localparam logic [GRID_W-1:0] MAX_GRID   = 9'd256;
  localparam logic [GRID_W-1:0] GRID_RESET = 9'd24;

  // one quotient bit per step
  localparam logic [DCNT_W-1:0] DIV_STEPS = 6'd33;

  // register indexes, byte address = 4 * index
  localparam logic [2:0] REG_COEF_CONST  = 3'd0;
  localparam logic [2:0] REG_COEF_X      = 3'd1;
  localparam logic [2:0] REG_COEF_Y      = 3'd2;
  localparam logic [2:0] REG_COEF_XX     = 3'd3;
  localparam logic [2:0] REG_COEF_XY     = 3'd4;
  localparam logic [2:0] REG_COEF_YY     = 3'd5;
  localparam logic [2:0] REG_GRID_POINTS = 3'd6;

  typedef enum logic [0:0] {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_TRI    = 2'd1,
    KIND_ERR    = 2'd2
  } kind_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIVX,
    ST_DIVY,
    ST_MPX,
    ST_MPY,
    ST_MXX,
    ST_MXY,
    ST_MYY,
    ST_MC1,
    ST_MC2,
    ST_MC3,
    ST_MC4,
    ST_MC5,
    ST_MIDX,
    ST_FIN,
    ST_EMIT_V,
    ST_EMIT_T1,
    ST_EMIT_T2,
    ST_EMIT_ERR
  } state_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIVD_W-1:0] dividend;
    logic [IDX_W-1:0]         divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] quotient;
  } div_rsp_t;

  localparam logic signed [ACC_W-1:0] SAT_MAX = 52'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -52'sd2147483648;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/qgmb_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qgmb_div
// Restoring divider for the grid step: signed extent over an 8-bit count,
// truncating toward zero, one quotient bit per cycle, saturated to 32 bits.
// ----------------------------------------------------------------------------
module qgmb_div (
  input  logic               clk,
  input  logic               rst_n,
  input  qgmb_pkg::div_req_t req,
  output qgmb_pkg::div_rsp_t rsp
);
  import qgmb_pkg::*;

  logic              busy_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DIVD_W-1:0] quo_r;
  logic [IDX_W-1:0]  rem_r;
  logic [IDX_W-1:0]  div_r;
  logic              neg_r;

  logic [DIVD_W-1:0]   mag;
  logic [IDX_W:0]      rem_sh;
  logic [IDX_W:0]      rem_dif;
  logic                ge;
  logic [IDX_W-1:0]    rem_nxt;
  logic signed [DIVD_W:0] q_s;

  assign mag     = req.dividend[DIVD_W-1] ? DIVD_W'(-req.dividend) : req.dividend;
  assign rem_sh  = {rem_r, quo_r[DIVD_W-1]};
  assign rem_dif = rem_sh - {1'b0, div_r};
  assign ge      = (rem_sh >= {1'b0, div_r});
  assign rem_nxt = ge ? rem_dif[IDX_W-1:0] : rem_sh[IDX_W-1:0];

  // apply the sign to the magnitude quotient
  assign q_s = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

  assign rsp.done     = busy_r && (cnt_r == '0);
  assign rsp.quotient = sat32({{(ACC_W-DIVD_W-1){q_s[DIVD_W]}}, q_s});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_STEPS;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= mag;
      rem_r <= '0;
      div_r <= req.divisor;
      neg_r <= req.dividend[DIVD_W-1];
    end else if (busy_r && (cnt_r != '0)) begin
      quo_r <= {quo_r[DIVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/quadric_grid_mesh_builder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadric_grid_mesh_builder
// Triangle mesh of z = c0 + c1*x + c2*y + c3*x*x + c4*x*y + c5*y*y over an
// N x N grid, Q16.16 fixed point.
//
// Coefficients and N are written over the APB port; the user must write
// them only while the block is idle, which the block does not enforce. The
// input channel takes one transaction at a time: in_stall stays high until
// the current one is finished. A start latches the low corner, runs the
// step divider twice (x then y) at one bit per cycle and gives no result.
// An advance evaluates one grid point: the single shared 32x32 multiplier
// is used for eleven products in a row (coordinates, squares, terms, vertex
// index); a vertex is sent, and two triangles if no grid index is zero.
// An advance with no build open gives one error result. Results leave
// through one output register; a held result stays while out_stall is high,
// and the sequencer waits in its send step. Reset restores the
// configuration and control registers and idles the block.
// ----------------------------------------------------------------------------
module quadric_grid_mesh_builder (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  qgmb_pkg::op_t         in_opcode,
  input  logic signed [31:0]    in_corner_lo_x,
  input  logic signed [31:0]    in_corner_lo_y,
  input  logic signed [31:0]    in_corner_hi_x,
  input  logic signed [31:0]    in_corner_hi_y,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output qgmb_pkg::kind_t       out_kind,
  output logic signed [31:0]    out_pos_x,
  output logic signed [31:0]    out_pos_y,
  output logic signed [31:0]    out_pos_z,
  output logic [15:0]           out_index_a,
  output logic [15:0]           out_index_b,
  output logic [15:0]           out_index_c,
  output logic signed [31:0]    out_low_z,
  output logic signed [31:0]    out_high_z,
  output logic                  out_last_of_item,
  output logic                  out_build_done,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import qgmb_pkg::*;

  // configuration registers
  logic signed [DATA_W-1:0] coef_const_r, coef_x_r, coef_y_r;
  logic signed [DATA_W-1:0] coef_xx_r, coef_xy_r, coef_yy_r;
  logic [GRID_W-1:0]        grid_r;

  // build state
  state_t                   state_r, state_nxt;
  logic signed [DATA_W-1:0] origin_x_r, origin_y_r, step_x_r, step_y_r;
  logic signed [DIVD_W-1:0] dy_r;
  logic [IDX_W-1:0]         outer_r, inner_r;
  logic                     building_r;
  logic signed [DATA_W-1:0] min_r, max_r;

  // point datapath
  logic signed [DATA_W-1:0] px_r, py_r, xx_r, xy_r, yy_r, pz_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [63:0]       prod_r;
  logic [VIDX_W-1:0]        vidx_r;
  logic                     tri_r, done_r;

  // output register
  logic                     out_valid_r;
  kind_t                    o_kind_r;
  logic signed [DATA_W-1:0] o_px_r, o_py_r, o_pz_r, o_lo_r, o_hi_r;
  logic [VIDX_W-1:0]        o_a_r, o_b_r, o_c_r;
  logic                     o_last_r, o_done_r;

  // combinational
  logic                     in_acc, cfg_wr, slot_free, out_load;
  logic [2:0]               reg_idx;
  logic [GRID_W-1:0]        n_eff;
  logic [VIDX_W-1:0]        n_ext;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [ACC_W-1:0]  term_fl, coord_sum_x, coord_sum_y;
  logic signed [DIVD_W-1:0] dx_in, dy_in;
  logic signed [DATA_W-1:0] pz_c;
  logic [VIDX_W-1:0]        vidx_c, ia, ib, ic, id;
  logic                     first_c;
  logic [IDX_W:0]           inner_inc, outer_inc;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  kind_t                    o_kind;
  logic signed [DATA_W-1:0] o_px, o_py, o_pz;
  logic [VIDX_W-1:0]        o_a, o_b, o_c;
  logic                     o_last, o_done;

  qgmb_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_const_r <= '0;
      coef_x_r     <= '0;
      coef_y_r     <= '0;
      coef_xx_r    <= '0;
      coef_xy_r    <= '0;
      coef_yy_r    <= '0;
      grid_r       <= GRID_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_COEF_CONST:  coef_const_r <= pwdata;
        REG_COEF_X:      coef_x_r     <= pwdata;
        REG_COEF_Y:      coef_y_r     <= pwdata;
        REG_COEF_XX:     coef_xx_r    <= pwdata;
        REG_COEF_XY:     coef_xy_r    <= pwdata;
        REG_COEF_YY:     coef_yy_r    <= pwdata;
        REG_GRID_POINTS: grid_r       <= pwdata[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_COEF_CONST:  prdata = coef_const_r;
      REG_COEF_X:      prdata = coef_x_r;
      REG_COEF_Y:      prdata = coef_y_r;
      REG_COEF_XX:     prdata = coef_xx_r;
      REG_COEF_XY:     prdata = coef_xy_r;
      REG_COEF_YY:     prdata = coef_yy_r;
      REG_GRID_POINTS: prdata = {{(DATA_W-GRID_W){1'b0}}, grid_r};
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // shared helpers
  // --------------------------------------------------------------------------
  always_comb begin
    priority if (grid_r < MIN_GRID) begin
      n_eff = MIN_GRID;
    end else if (grid_r > MAX_GRID) begin
      n_eff = MAX_GRID;
    end else begin
      n_eff = grid_r;
    end
  end

  assign n_ext    = {{(VIDX_W-GRID_W){1'b0}}, n_eff};
  assign in_acc   = in_valid && !in_stall;
  assign dx_in    = {in_corner_hi_x[DATA_W-1], in_corner_hi_x}
                  - {in_corner_lo_x[DATA_W-1], in_corner_lo_x};
  assign dy_in    = {in_corner_hi_y[DATA_W-1], in_corner_hi_y}
                  - {in_corner_lo_y[DATA_W-1], in_corner_lo_y};

  // floor by 2^16 is the upper part of the product
  assign term_fl     = {{(ACC_W-48){prod_r[63]}}, prod_r[63:16]};
  assign coord_sum_x = {{(ACC_W-DATA_W){origin_x_r[DATA_W-1]}}, origin_x_r}
                     + prod_r[ACC_W-1:0];
  assign coord_sum_y = {{(ACC_W-DATA_W){origin_y_r[DATA_W-1]}}, origin_y_r}
                     + prod_r[ACC_W-1:0];

  assign pz_c      = sat32(acc_r);
  assign vidx_c    = prod_r[VIDX_W-1:0] + {{(VIDX_W-IDX_W){1'b0}}, inner_r};
  assign first_c   = (outer_r == '0) && (inner_r == '0);
  assign inner_inc = {1'b0, inner_r} + 1'b1;
  assign outer_inc = {1'b0, outer_r} + 1'b1;

  // corners of the cell that ends at the current point
  assign ia = vidx_r - n_ext - 16'd1;
  assign ib = ia + 16'd1;
  assign ic = ia + n_ext;
  assign id = ib + n_ext;

  assign slot_free = !out_valid_r || !out_stall;

  // --------------------------------------------------------------------------
  // sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_opcode == OP_START) begin
            state_nxt = ST_DIVX;
          end else if (building_r) begin
            state_nxt = ST_MPX;
          end else begin
            state_nxt = ST_EMIT_ERR;
          end
        end
      end
      ST_DIVX:     if (div_rsp.done) state_nxt = ST_DIVY;
      ST_DIVY:     if (div_rsp.done) state_nxt = ST_IDLE;
      ST_MPX:      state_nxt = ST_MPY;
      ST_MPY:      state_nxt = ST_MXX;
      ST_MXX:      state_nxt = ST_MXY;
      ST_MXY:      state_nxt = ST_MYY;
      ST_MYY:      state_nxt = ST_MC1;
      ST_MC1:      state_nxt = ST_MC2;
      ST_MC2:      state_nxt = ST_MC3;
      ST_MC3:      state_nxt = ST_MC4;
      ST_MC4:      state_nxt = ST_MC5;
      ST_MC5:      state_nxt = ST_MIDX;
      ST_MIDX:     state_nxt = ST_FIN;
      ST_FIN:      state_nxt = ST_EMIT_V;
      ST_EMIT_V: begin
        if (slot_free) state_nxt = tri_r ? ST_EMIT_T1 : ST_IDLE;
      end
      ST_EMIT_T1:  if (slot_free) state_nxt = ST_EMIT_T2;
      ST_EMIT_T2:  if (slot_free) state_nxt = ST_IDLE;
      ST_EMIT_ERR: if (slot_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_stall         = (state_r != ST_IDLE);
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = dy_r;
    div_req.divisor  = IDX_W'(n_eff - 1'b1);
    out_load         = 1'b0;
    o_kind           = KIND_VERTEX;
    o_px             = '0;
    o_py             = '0;
    o_pz             = '0;
    o_a              = '0;
    o_b              = '0;
    o_c              = '0;
    o_last           = 1'b0;
    o_done           = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        div_req.dividend = dx_in;
        div_req.start    = in_acc && (in_opcode == OP_START);
      end
      ST_DIVX: div_req.start = div_rsp.done;
      ST_DIVY: ;
      ST_MPX: begin
        mul_a = step_x_r;
        mul_b = {{(DATA_W-IDX_W){1'b0}}, outer_r};
      end
      ST_MPY: begin
        mul_a = step_y_r;
        mul_b = {{(DATA_W-IDX_W){1'b0}}, inner_r};
      end
      ST_MXX: begin
        mul_a = px_r;
        mul_b = px_r;
      end
      ST_MXY: begin
        mul_a = px_r;
        mul_b = py_r;
      end
      ST_MYY: begin
        mul_a = py_r;
        mul_b = py_r;
      end
      ST_MC1: begin
        mul_a = coef_x_r;
        mul_b = px_r;
      end
      ST_MC2: begin
        mul_a = coef_y_r;
        mul_b = py_r;
      end
      ST_MC3: begin
        mul_a = coef_xx_r;
        mul_b = xx_r;
      end
      ST_MC4: begin
        mul_a = coef_xy_r;
        mul_b = xy_r;
      end
      ST_MC5: begin
        mul_a = coef_yy_r;
        mul_b = yy_r;
      end
      ST_MIDX: begin
        mul_a = {{(DATA_W-GRID_W){1'b0}}, n_eff};
        mul_b = {{(DATA_W-IDX_W){1'b0}}, outer_r};
      end
      ST_FIN: ;
      ST_EMIT_V: begin
        out_load = slot_free;
        o_kind   = KIND_VERTEX;
        o_px     = px_r;
        o_py     = py_r;
        o_pz     = pz_r;
        o_a      = vidx_r;
        o_last   = !tri_r;
        o_done   = !tri_r && done_r;
      end
      ST_EMIT_T1: begin
        out_load = slot_free;
        o_kind   = KIND_TRI;
        o_a      = ia;
        o_b      = ic;
        o_c      = ib;
      end
      ST_EMIT_T2: begin
        out_load = slot_free;
        o_kind   = KIND_TRI;
        o_a      = ib;
        o_b      = ic;
        o_c      = id;
        o_last   = 1'b1;
        o_done   = done_r;
      end
      ST_EMIT_ERR: begin
        out_load = slot_free;
        o_kind   = KIND_ERR;
        o_last   = 1'b1;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      building_r  <= 1'b0;
      outer_r     <= '0;
      inner_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (state_r == ST_IDLE && in_acc && in_opcode == OP_START) begin
        outer_r <= '0;
        inner_r <= '0;
      end

      if (state_r == ST_DIVY && div_rsp.done) begin
        building_r <= 1'b1;
      end

      // advance the grid counters, wrap inner, end the build on the last row
      if (state_r == ST_FIN) begin
        if (inner_inc >= n_eff) begin
          inner_r <= '0;
          if (outer_inc >= n_eff) begin
            outer_r    <= '0;
            building_r <= 1'b0;
          end else begin
            outer_r <= outer_inc[IDX_W-1:0];
          end
        end else begin
          inner_r <= inner_inc[IDX_W-1:0];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_opcode == OP_START) begin
          origin_x_r <= in_corner_lo_x;
          origin_y_r <= in_corner_lo_y;
          dy_r       <= dy_in;
        end
      end
      ST_DIVX: if (div_rsp.done) step_x_r <= div_rsp.quotient;
      ST_DIVY: if (div_rsp.done) step_y_r <= div_rsp.quotient;
      ST_MPX:  ;
      ST_MPY:  px_r <= sat32(coord_sum_x);
      ST_MXX:  py_r <= sat32(coord_sum_y);
      ST_MXY:  xx_r <= sat32(term_fl);
      ST_MYY:  xy_r <= sat32(term_fl);
      ST_MC1:  yy_r <= sat32(term_fl);
      ST_MC2:  acc_r <= {{(ACC_W-DATA_W){coef_const_r[DATA_W-1]}}, coef_const_r} + term_fl;
      ST_MC3:  acc_r <= acc_r + term_fl;
      ST_MC4:  acc_r <= acc_r + term_fl;
      ST_MC5:  acc_r <= acc_r + term_fl;
      ST_MIDX: acc_r <= acc_r + term_fl;
      ST_FIN: begin
        pz_r   <= pz_c;
        vidx_r <= vidx_c;
        tri_r  <= (outer_r != '0) && (inner_r != '0);
        done_r <= (inner_inc >= n_eff) && (outer_inc >= n_eff);
        // first point sets both bounds, later ones move at most one
        priority if (first_c) begin
          min_r <= pz_c;
          max_r <= pz_c;
        end else if (min_r > pz_c) begin
          min_r <= pz_c;
        end else if (max_r < pz_c) begin
          max_r <= pz_c;
        end
      end
      default: ;
    endcase
  end

  // hold the result while the receiver stalls
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_kind_r <= o_kind;
      o_px_r   <= o_px;
      o_py_r   <= o_py;
      o_pz_r   <= o_pz;
      o_a_r    <= o_a;
      o_b_r    <= o_b;
      o_c_r    <= o_c;
      o_lo_r   <= (o_kind == KIND_ERR) ? '0 : min_r;
      o_hi_r   <= (o_kind == KIND_ERR) ? '0 : max_r;
      o_last_r <= o_last;
      o_done_r <= o_done;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = o_kind_r;
  assign out_pos_x        = o_px_r;
  assign out_pos_y        = o_py_r;
  assign out_pos_z        = o_pz_r;
  assign out_index_a      = o_a_r;
  assign out_index_b      = o_b_r;
  assign out_index_c      = o_c_r;
  assign out_low_z        = o_lo_r;
  assign out_high_z       = o_hi_r;
  assign out_last_of_item = o_last_r;
  assign out_build_done   = o_done_r;

endmodule
`default_nettype wire

@@ tb/sv/mesh_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_result_checker
// Watches the register bus and both streaming channels of the quadric grid
// mesh builder, predicts the vertex, triangle and error results of every
// accepted transaction, and compares them field by field in order.
// ----------------------------------------------------------------------------
module mesh_result_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  qgmb_pkg::op_t         in_opcode,
  input  logic signed [31:0]    in_corner_lo_x,
  input  logic signed [31:0]    in_corner_lo_y,
  input  logic signed [31:0]    in_corner_hi_x,
  input  logic signed [31:0]    in_corner_hi_y,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  qgmb_pkg::kind_t       out_kind,
  input  logic signed [31:0]    out_pos_x,
  input  logic signed [31:0]    out_pos_y,
  input  logic signed [31:0]    out_pos_z,
  input  logic [15:0]           out_index_a,
  input  logic [15:0]           out_index_b,
  input  logic [15:0]           out_index_c,
  input  logic signed [31:0]    out_low_z,
  input  logic signed [31:0]    out_high_z,
  input  logic                  out_last_of_item,
  input  logic                  out_build_done,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    awaiting
);
  import qgmb_pkg::*;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  typedef struct {
    kind_t       kind;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [15:0] idx_a;
    logic [15:0] idx_b;
    logic [15:0] idx_c;
    logic [31:0] low_z;
    logic [31:0] high_z;
    logic        last;
    logic        done;
  } mesh_result_t;

  mesh_result_t expected_q[$];
  mesh_result_t head_r;
  int           mismatches = 0;

  // mirrored registers and build state
  longint       coef[6];
  logic [8:0]   grid_reg;
  longint       org_x, org_y, stp_x, stp_y;
  longint       col, row;
  longint       zmin, zmax;
  bit           building;

  initial begin
    fail_count = 0;
    awaiting   = 0;
  end

  function automatic longint clip32(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic longint eff_grid();
    if (grid_reg < MIN_GRID) return longint'(MIN_GRID);
    if (grid_reg > MAX_GRID) return longint'(MAX_GRID);
    return longint'(grid_reg);
  endfunction

  function automatic longint height_at(input longint x, input longint y);
    longint sq_x, prod_xy, sq_y, acc;
    sq_x    = clip32((x * x) >>> 16);
    prod_xy = clip32((x * y) >>> 16);
    sq_y    = clip32((y * y) >>> 16);
    acc = coef[REG_COEF_CONST]
        + ((coef[REG_COEF_X] * x) >>> 16)
        + ((coef[REG_COEF_Y] * y) >>> 16)
        + ((coef[REG_COEF_XX] * sq_x) >>> 16)
        + ((coef[REG_COEF_XY] * prod_xy) >>> 16)
        + ((coef[REG_COEF_YY] * sq_y) >>> 16);
    return clip32(acc);
  endfunction

  function automatic mesh_result_t make_result(input kind_t k, input longint px,
                                               input longint py, input longint pz,
                                               input longint a, input longint b,
                                               input longint c, input longint lo,
                                               input longint hi, input bit last,
                                               input bit done);
    mesh_result_t r;
    r.kind   = k;
    r.pos_x  = px[31:0];
    r.pos_y  = py[31:0];
    r.pos_z  = pz[31:0];
    r.idx_a  = a[15:0];
    r.idx_b  = b[15:0];
    r.idx_c  = c[15:0];
    r.low_z  = lo[31:0];
    r.high_z = hi[31:0];
    r.last   = last;
    r.done   = done;
    return r;
  endfunction

  task automatic predict_point();
    longint n, lx, ly, hx, hy, x, y, px, py, pz, ia, ib;
    bit     has_tri, done;
    n = eff_grid();
    if (in_opcode == OP_START) begin
      lx = longint'(in_corner_lo_x);
      ly = longint'(in_corner_lo_y);
      hx = longint'(in_corner_hi_x);
      hy = longint'(in_corner_hi_y);
      org_x = lx;
      org_y = ly;
      stp_x = clip32((hx - lx) / (n - 1));
      stp_y = clip32((hy - ly) / (n - 1));
      col = 0;
      row = 0;
      building = 1'b1;
    end else if (!building) begin
      expected_q.push_back(make_result(KIND_ERR, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0));
    end else begin
      x  = col;
      y  = row;
      px = clip32(org_x + stp_x * x);
      py = clip32(org_y + stp_y * y);
      pz = height_at(px, py);
      has_tri = (x != 0) && (y != 0);
      done    = 1'b0;
      // the first point seeds both extremes; otherwise only one may move
      if (x == 0 && y == 0) begin
        zmin = pz;
        zmax = pz;
      end else if (zmin > pz) begin
        zmin = pz;
      end else if (zmax < pz) begin
        zmax = pz;
      end
      if (y + 1 >= n) begin
        row = 0;
        if (x + 1 >= n) begin
          col = 0;
          building = 1'b0;
          done = 1'b1;
        end else begin
          col = x + 1;
        end
      end else begin
        row = y + 1;
      end
      expected_q.push_back(make_result(KIND_VERTEX, px, py, pz, x * n + y, 0, 0,
                                       zmin, zmax, !has_tri, !has_tri && done));
      if (has_tri) begin
        ia = (x - 1) * n + (y - 1);
        ib = ia + 1;
        expected_q.push_back(make_result(KIND_TRI, 0, 0, 0, ia, ia + n, ib,
                                         zmin, zmax, 1'b0, 1'b0));
        expected_q.push_back(make_result(KIND_TRI, 0, 0, 0, ib, ia + n, ib + n,
                                         zmin, zmax, 1'b1, done));
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %08h, actual %08h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (coef[i]) coef[i] = 0;
      grid_reg = GRID_RESET;
      org_x = 0;
      org_y = 0;
      stp_x = 0;
      stp_y = 0;
      col = 0;
      row = 0;
      zmin = 0;
      zmax = 0;
      building = 1'b0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_COEF_CONST:  coef[REG_COEF_CONST] = longint'($signed(pwdata));
          REG_COEF_X:      coef[REG_COEF_X]     = longint'($signed(pwdata));
          REG_COEF_Y:      coef[REG_COEF_Y]     = longint'($signed(pwdata));
          REG_COEF_XX:     coef[REG_COEF_XX]    = longint'($signed(pwdata));
          REG_COEF_XY:     coef[REG_COEF_XY]    = longint'($signed(pwdata));
          REG_COEF_YY:     coef[REG_COEF_YY]    = longint'($signed(pwdata));
          REG_GRID_POINTS: grid_reg             = pwdata[8:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction: kind %0d", out_kind);
          mismatches++;
        end else begin
          head_r = expected_q.pop_front();
          check_field("kind", 32'(head_r.kind), 32'(out_kind));
          check_field("pos_x", head_r.pos_x, out_pos_x);
          check_field("pos_y", head_r.pos_y, out_pos_y);
          check_field("pos_z", head_r.pos_z, out_pos_z);
          check_field("index_a", 32'(head_r.idx_a), 32'(out_index_a));
          check_field("index_b", 32'(head_r.idx_b), 32'(out_index_b));
          check_field("index_c", 32'(head_r.idx_c), 32'(out_index_c));
          check_field("low_z", head_r.low_z, out_low_z);
          check_field("high_z", head_r.high_z, out_high_z);
          check_field("last_of_item", 32'(head_r.last), 32'(out_last_of_item));
          check_field("build_done", 32'(head_r.done), 32'(out_build_done));
        end
      end
      if (in_valid && !in_stall) predict_point();
    end
    fail_count <= mismatches;
    awaiting   <= expected_q.size();
  end

endmodule

@@ tb/sv/tb_quadric_grid_mesh_builder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadric_grid_mesh_builder
// Drives the quadric grid mesh builder: register setup over the APB port,
// directed builds on a small grid, then random phases of builds, restarts,
// mid-build grid changes and stray advances, with bursty input and a
// patterned output stall. Checking lives in mesh_result_checker.
// ----------------------------------------------------------------------------
module tb_quadric_grid_mesh_builder;
  import qgmb_pkg::*;

  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int ITEM_TARGET  = 210;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  op_t                in_opcode = OP_START;
  logic signed [31:0] in_corner_lo_x = '0;
  logic signed [31:0] in_corner_lo_y = '0;
  logic signed [31:0] in_corner_hi_x = '0;
  logic signed [31:0] in_corner_hi_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  kind_t              out_kind;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic [15:0]        out_index_a, out_index_b, out_index_c;
  logic signed [31:0] out_low_z, out_high_z;
  logic               out_last_of_item, out_build_done;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int                 fail_count;
  int                 awaiting;
  int                 cycle_count = 0;
  int                 items_sent = 0;
  int                 burst_left = 0;
  logic [8:0]         grid_now = GRID_RESET;
  bit                 hold_req = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  quadric_grid_mesh_builder uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_corner_lo_x(in_corner_lo_x), .in_corner_lo_y(in_corner_lo_y),
    .in_corner_hi_x(in_corner_hi_x), .in_corner_hi_y(in_corner_hi_y),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_index_a(out_index_a), .out_index_b(out_index_b), .out_index_c(out_index_c),
    .out_low_z(out_low_z), .out_high_z(out_high_z),
    .out_last_of_item(out_last_of_item), .out_build_done(out_build_done),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  mesh_result_checker mesh_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_corner_lo_x(in_corner_lo_x), .in_corner_lo_y(in_corner_lo_y),
    .in_corner_hi_x(in_corner_hi_x), .in_corner_hi_y(in_corner_hi_y),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_index_a(out_index_a), .out_index_b(out_index_b), .out_index_c(out_index_c),
    .out_low_z(out_low_z), .out_high_z(out_high_z),
    .out_last_of_item(out_last_of_item), .out_build_done(out_build_done),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .awaiting(awaiting)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3, 4: return $urandom;
      default: return $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_corner();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return $urandom_range(0, 32'hF_FFFF) - 32'h8_0000;
    endcase
  endfunction

  function automatic logic [8:0] pick_grid();
    case ($urandom_range(0, 15))
      9:  return 9'($urandom_range(0, 3));
      10: return MAX_GRID;
      11: return MAX_GRID - 9'd1;
      12: return 9'($urandom_range(257, 511));
      13: return 9'h1FF;
      14: return 9'($urandom);
      default: return MIN_GRID + 9'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic int eff_n();
    if (grid_now < MIN_GRID) return int'(MIN_GRID);
    if (grid_now > MAX_GRID) return int'(MAX_GRID);
    return int'(grid_now);
  endfunction

  task automatic cfg_write(input logic [2:0] reg_idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_GRID_POINTS) grid_now = value[8:0];
  endtask

  task automatic send_item(input op_t op, input logic [31:0] lx, input logic [31:0] ly,
                           input logic [31:0] hx, input logic [31:0] hy);
    int gap;
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_corner_lo_x <= lx;
    in_corner_lo_y <= ly;
    in_corner_hi_x <= hx;
    in_corner_hi_y <= hy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    // end of burst: maybe drop valid for a while
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_advance();
    send_item(OP_ADVANCE, rand_corner(), rand_corner(), rand_corner(), rand_corner());
  endtask

  task automatic send_start();
    send_item(OP_START, rand_corner(), rand_corner(), rand_corner(), rand_corner());
  endtask

  // hold input off until every predicted result is out and the block is quiet
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase();
    int n;
    int count;
    wait_quiet();
    if ($urandom_range(0, 1)) cfg_write(REG_COEF_CONST, rand_coef());
    if ($urandom_range(0, 1)) cfg_write(REG_COEF_X, rand_coef());
    if ($urandom_range(0, 1)) cfg_write(REG_COEF_Y, rand_coef());
    if ($urandom_range(0, 1)) cfg_write(REG_COEF_XX, rand_coef());
    if ($urandom_range(0, 1)) cfg_write(REG_COEF_XY, rand_coef());
    if ($urandom_range(0, 1)) cfg_write(REG_COEF_YY, rand_coef());
    if ($urandom_range(0, 3) != 0) cfg_write(REG_GRID_POINTS, {23'd0, pick_grid()});
    n = eff_n();
    case ($urandom_range(0, 9))
      7: begin
        repeat (10) begin
          send_item(op_t'($urandom_range(0, 1)), rand_corner(), rand_corner(),
                    rand_corner(), rand_corner());
        end
      end
      8: begin
        // continue whatever build is open, possibly on a new grid size
        repeat ($urandom_range(4, 10)) send_advance();
      end
      9: begin
        send_start();
        repeat ($urandom_range(1, 5)) send_advance();
        send_start();
        repeat ($urandom_range(2, 8)) send_advance();
      end
      default: begin
        send_start();
        count = (n * n <= 49) ? n * n + $urandom_range(0, 2) : $urandom_range(3, 12);
        repeat (count) send_advance();
      end
    endcase
  endtask

  // output stall pattern, with one long hold-off once requested
  initial begin
    int seg;
    int mode;
    bit hold_done;
    hold_done = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      seg  = $urandom_range(1, 40);
      mode = $urandom_range(0, 3);
      for (int k = 0; k < seg; k++) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= k[0];
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // advance straight out of reset: idle error
    send_item(OP_ADVANCE, '0, '0, '0, '0);
    wait_quiet();
    cfg_write(REG_COEF_CONST, 32'h0001_8000);
    cfg_write(REG_COEF_X, 32'h0002_0000);
    cfg_write(REG_COEF_Y, 32'hFFFF_0000);
    cfg_write(REG_COEF_XX, 32'h0000_8000);
    cfg_write(REG_COEF_XY, 32'h8000_0000);
    cfg_write(REG_COEF_YY, 32'h7FFF_FFFF);
    // below the minimum: clamps to the smallest grid
    cfg_write(REG_GRID_POINTS, 32'd0);

    // full build with the widest x extent
    send_item(OP_START, 32'h8000_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h0003_0000);
    repeat (16) send_advance();
    // build finished: back to idle
    send_advance();
    // reversed corners give negative steps
    send_item(OP_START, 32'h7FFF_FFFF, 32'h0010_0000, 32'h8000_0000, 32'hFFF0_0000);
    repeat (2) send_advance();
    // restart while building
    send_item(OP_START, 32'hFFFE_0000, 32'h0000_4000, 32'h0002_0000, 32'h0004_0000);
    repeat (2) send_advance();

    // start the long hold-off only once the block is empty
    wait_quiet();
    hold_req = 1'b1;
    while (items_sent < ITEM_TARGET) run_phase();

    wait_quiet();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
